>>> rtl/assert_macros.svh
// assertion macros shared by the rasterizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// condition implies property in the same cycle
`define DTLR_CHECK_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("rasterizer check failed");
// condition implies property in the next cycle
`define DTLR_CHECK_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("rasterizer check failed");
`else
`define DTLR_CHECK_NOW(label, clk, rst, cond, prop)
`define DTLR_CHECK_NEXT(label, clk, rst, cond, prop)
`endif
`endif

>>> rtl/dtlr_pkg.sv
// types and constants of the depth-tested line rasterizer
`timescale 1ns / 1ps
package dtlr_pkg;

  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_STEPS   = 4096;

  localparam int COL_W  = $clog2(MAX_COLUMNS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ADDR_W = COL_W + ROW_W;
  localparam int CELLS  = MAX_COLUMNS * MAX_ROWS;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);

  localparam int COUNT_W = 14;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic signed [31:0] DEPTH_EMPTY = 32'sh7FFF_FFFF;

  // projection arithmetic
  localparam int Z_OFFSET   = 655360;
  localparam int Z_NEAR     = 655;
  localparam int PROJ_SCALE = 200;
  localparam int SPAN_W     = 16;
  localparam int ZZ_W       = 34;
  localparam int T1_W       = 41;
  localparam int T2_W       = 51;
  localparam int NUM_W      = 52;
  typedef logic signed [ZZ_W-1:0] zz_t;
  localparam zz_t ZZ_OFFSET   = zz_t'(Z_OFFSET);
  localparam zz_t ZZ_NEAR_POS = zz_t'(Z_NEAR);
  localparam zz_t ZZ_NEAR_NEG = -zz_t'(Z_NEAR);

  // shared iterative units
  localparam int DIV_W  = 64;
  localparam int SQRT_W = 64;
  localparam int ROOT_W = SQRT_W / 2;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_POINT,
    MODE_LINE,
    MODE_READ
  } mode_t;

  typedef struct packed {
    logic              marked;
    logic [2:0]        color;
    logic signed [31:0] depth;
  } cell_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PRJ_Z,
    ST_PRJ_MUL,
    ST_PRJ_SUM,
    ST_PRJ_DIV,
    ST_PRJ_WAIT,
    ST_DELTA,
    ST_SQ_A,
    ST_SQ_B,
    ST_LEN_SQRT,
    ST_LEN_WAIT,
    ST_SHIFT,
    ST_UV_A,
    ST_UV_B,
    ST_UNIT_SQRT,
    ST_UNIT_WAIT,
    ST_INC_DIV,
    ST_INC_WAIT,
    ST_SETUP,
    ST_STEP_RD,
    ST_STEP_WR,
    ST_READ,
    ST_READ_DATA,
    ST_DONE
  } st_t;

endpackage

>>> rtl/dtlr_if.sv
// handshake channels of the rasterizer: items in, results out, register writes
`timescale 1ns / 1ps
interface dtlr_item_if;
  import dtlr_pkg::*;
  logic               valid;
  logic               ready;
  mode_t              mode;
  logic signed [31:0] start_x;
  logic signed [31:0] start_y;
  logic signed [31:0] start_z;
  logic signed [31:0] end_x;
  logic signed [31:0] end_y;
  logic signed [31:0] end_z;
  logic [2:0]         line_color;
  logic [6:0]         read_column;
  logic [5:0]         read_row;
  modport source(output valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
                 line_color, read_column, read_row, input ready);
  modport sink(input valid, mode, start_x, start_y, start_z, end_x, end_y, end_z,
               line_color, read_column, read_row, output ready);
endinterface

interface dtlr_result_if;
  logic               valid;
  logic               ready;
  logic               cell_marked;
  logic [2:0]         cell_color;
  logic signed [31:0] cell_depth;
  logic [13:0]        cells_written;
  logic               truncated;
  modport source(output valid, cell_marked, cell_color, cell_depth, cells_written,
                 truncated, input ready);
  modport sink(input valid, cell_marked, cell_color, cell_depth, cells_written,
               truncated, output ready);
endinterface

interface dtlr_cfg_if;
  import dtlr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/dtlr_div.sv
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module dtlr_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [dtlr_pkg::DIV_W-1:0]   dividend,
  input  logic [dtlr_pkg::DIV_W-1:0]   divisor,
  output dtlr_pkg::unit_stat_t         stat,
  output logic [dtlr_pkg::DIV_W-1:0]   quotient
);
  import dtlr_pkg::*;

  logic                       busy;
  logic                       done;
  logic [$clog2(DIV_W)-1:0]   cnt;
  logic [DIV_W-1:0]           rem;
  logic [DIV_W-1:0]           quo;
  logic [DIV_W-1:0]           dvs;
  logic [DIV_W:0]             trial;
  logic [DIV_W:0]             diff;
  logic                       take;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    diff  = trial - {1'b0, dvs};
    take  = !diff[DIV_W];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      rem <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], take};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

>>> rtl/dtlr_sqrt.sv
// integer square root, two radicand bits per cycle, with remainder flag
`timescale 1ns / 1ps
module dtlr_sqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [dtlr_pkg::SQRT_W-1:0]   radicand,
  output dtlr_pkg::unit_stat_t          stat,
  output logic [dtlr_pkg::ROOT_W-1:0]   root,
  output logic                          rem_nz
);
  import dtlr_pkg::*;

  logic                       busy;
  logic                       done;
  logic [$clog2(ROOT_W)-1:0]  cnt;
  logic [SQRT_W-1:0]          s;
  logic [SQRT_W-1:0]          r;
  logic [SQRT_W-1:0]          bitv;
  logic [SQRT_W-1:0]          sum;
  logic                       fits;

  always_comb begin
    sum  = r + bitv;
    fits = (s >= sum);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // digit-by-digit root
  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      s    <= radicand;
      r    <= '0;
      bitv <= {2'b01, {(SQRT_W-2){1'b0}}};
    end else if (busy) begin
      cnt  <= cnt + 1'b1;
      bitv <= bitv >> 2;
      if (fits) begin
        s <= s - sum;
        r <= (r >> 1) + bitv;
      end else begin
        r <= r >> 1;
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = r[ROOT_W-1:0];
  assign rem_nz    = (s != '0);

endmodule

>>> rtl/depth_tested_line_rasterizer_core.sv
// top level: depth-tested point and line rasterizer over a character-cell frame
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channels: item (mode, endpoints, color, read cell) in, result out, cfg for
// the screen_width / screen_height registers; each moves one transfer when
// valid and ready are both high. cfg is always ready.
// The frame lives in one single-port-write memory of 8192 cells holding
// mark, color and depth; every draw step is a read, a depth compare and a
// conditional write back, over the states ST_STEP_RD and ST_STEP_WR.
// Work per item, from the item transfer to result valid, one item at a time:
//   read  : one registered read of the frame memory cell
//   clear : a clearing pass, one cell written per cycle
//   point : two projections through the shared divider
//   line  : four projections, two square roots and three divides, with an
//           operand shift of at most 17 places, then the memory
//           read-modify-write loop over at most 4096 steps
// The result sits in an output register; a finished result waits in the core
// if the previous one has not yet been taken, and item is taken again only
// once the finished result has moved into the output register.
// Reset: a clearing pass sets every cell empty; item.ready is low during the
// pass, register writes are taken throughout.
module depth_tested_line_rasterizer_core (
  input logic        clk,
  input logic        rst,
  dtlr_item_if.sink      item,
  dtlr_result_if.source  result,
  dtlr_cfg_if.sink       cfg
);
  import dtlr_pkg::*;

  st_t state;
  st_t state_next;

  // registers
  logic [7:0] screen_width;
  logic [6:0] screen_height;
  logic [SPAN_W-1:0] eff_w;
  logic [SPAN_W-1:0] eff_h;

  // latched item
  mode_t              cur_mode;
  logic signed [31:0] cur_sx, cur_sy, cur_sz, cur_ex, cur_ey, cur_ez;
  logic [2:0]         cur_color;
  logic [6:0]         cur_col;
  logic [5:0]         cur_row;

  // projection
  logic [1:0]               proj_idx;
  logic signed [31:0]       p_coord;
  logic signed [31:0]       p_z;
  logic [SPAN_W-1:0]        p_span;
  zz_t                      zz_raw;
  zz_t                      zz_c;
  zz_t                      zz;
  zz_t                      zz_mag;
  logic signed [T1_W-1:0]   t1;
  logic signed [T2_W-1:0]   t2;
  logic signed [NUM_W-1:0]  num;
  logic signed [NUM_W-1:0]  num_mag;
  logic                     q_neg;
  logic signed [31:0]       pc [4];

  // line setup
  logic signed [32:0] dx, dy, dz;
  logic               dx_neg, dy_neg, dz_neg;
  logic [31:0]        ax, ay, az;
  logic [31:0]        mul_op;
  logic [63:0]        sq_p;
  logic [63:0]        sq_a, sq_b;
  logic [63:0]        sq_sum;
  logic [32:0]        n_full;
  logic [STEP_W-1:0]  n;
  logic [STEP_W-1:0]  k;
  logic [31:0]        u, v;
  logic [4:0]         sh;
  logic [31:0]        lq;
  logic [1:0]         inc_idx;
  logic [DIV_W-1:0]   inc_mag;
  logic signed [63:0] incx, incy, incz;
  logic signed [63:0] px, py, pz;

  // step
  logic [33:0]        col_full, row_full;
  logic [49:0]        z_full;
  logic signed [31:0] zq;
  logic               on_screen;
  logic               st_on;
  logic signed [31:0] st_z;
  logic [ADDR_W-1:0]  st_addr;
  logic               pass;
  logic               rd_in_range;

  // shared units
  logic             div_start;
  logic [DIV_W-1:0] div_a, div_b, div_q;
  unit_stat_t       div_stat;
  logic              sqrt_start;
  logic [SQRT_W-1:0] sqrt_in;
  logic [ROOT_W-1:0] sqrt_root;
  logic              sqrt_rem_nz;
  unit_stat_t        sqrt_stat;

  // frame memory
  cell_t             mem [CELLS];
  cell_t             mem_rdata;
  cell_t             mem_wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] clr_addr;
  logic              clr_item;

  // result
  logic               res_marked;
  logic [2:0]         res_color;
  logic signed [31:0] res_depth;
  logic [COUNT_W-1:0] count;
  logic               trunc;
  logic               out_load;
  logic               out_valid;
  logic               out_marked;
  logic [2:0]         out_color;
  logic signed [31:0] out_depth;
  logic [COUNT_W-1:0] out_count;
  logic               out_trunc;

  // screen size limited to the store
  always_comb begin
    eff_w = (SPAN_W'(screen_width) > SPAN_W'(MAX_COLUMNS)) ? SPAN_W'(MAX_COLUMNS)
                                                           : SPAN_W'(screen_width);
    eff_h = (SPAN_W'(screen_height) > SPAN_W'(MAX_ROWS)) ? SPAN_W'(MAX_ROWS)
                                                         : SPAN_W'(screen_height);
  end

  // projection operand select and near-plane clamp
  always_comb begin
    unique case (proj_idx)
      2'd0: begin p_coord = cur_sx; p_z = cur_sz; p_span = eff_w; end
      2'd1: begin p_coord = cur_sy; p_z = cur_sz; p_span = eff_h; end
      2'd2: begin p_coord = cur_ex; p_z = cur_ez; p_span = eff_w; end
      default: begin p_coord = cur_ey; p_z = cur_ez; p_span = eff_h; end
    endcase
    zz_raw = ZZ_W'(p_z) + ZZ_OFFSET;
    if (zz_raw >= zz_t'(0) && zz_raw < ZZ_NEAR_POS) begin
      zz_c = ZZ_NEAR_POS;
    end else if (zz_raw < zz_t'(0) && zz_raw > ZZ_NEAR_NEG) begin
      zz_c = ZZ_NEAR_NEG;
    end else begin
      zz_c = zz_raw;
    end
    num_mag = num[NUM_W-1] ? -num : num;
    zz_mag  = zz[ZZ_W-1] ? -zz : zz;
  end

  // endpoint deltas, squaring and step count
  always_comb begin
    dx = 33'(pc[2]) - 33'(pc[0]);
    dy = 33'(pc[3]) - 33'(pc[1]);
    dz = 33'(cur_ez) - 33'(cur_sz);
    unique case (state)
      ST_SQ_A: mul_op = ax;
      ST_SQ_B: mul_op = ay;
      ST_UV_A: mul_op = u;
      default: mul_op = v;
    endcase
    sq_p    = 64'(mul_op) * 64'(mul_op);
    sq_sum  = sq_a + sq_b;
    n_full  = {1'b0, sqrt_root} + {32'b0, sqrt_rem_nz};
    inc_mag = div_q >> sh;
  end

  // unit operands
  always_comb begin
    if (state == ST_INC_DIV) begin
      unique case (inc_idx)
        2'd0:    div_a = DIV_W'(u) << 46;
        2'd1:    div_a = DIV_W'(v) << 46;
        default: div_a = DIV_W'(az) << 30;
      endcase
      div_b = DIV_W'(lq);
    end else begin
      div_a = DIV_W'($unsigned(num_mag));
      div_b = DIV_W'($unsigned({zz_mag, 1'b0}));
    end
    sqrt_in = (state == ST_UNIT_SQRT) ? {sq_sum[31:0], 32'b0} : sq_sum;
  end

  // current cell of the step, truncated toward zero, and its depth
  always_comb begin
    col_full  = px[63:30] + {33'b0, px[63] && (|px[29:0])};
    row_full  = py[63:30] + {33'b0, py[63] && (|py[29:0])};
    z_full    = pz[63:14] + {49'b0, pz[63] && (|pz[13:0])};
    if (&z_full[49:31] || !(|z_full[49:31])) begin
      zq = z_full[31:0];
    end else begin
      zq = z_full[49] ? 32'sh8000_0000 : DEPTH_EMPTY;
    end
    on_screen = !col_full[33] && (col_full < 34'(eff_w)) &&
                !row_full[33] && (row_full < 34'(eff_h));
    pass        = st_on && (st_z < mem_rdata.depth);
    rd_in_range = (32'(cur_col) < MAX_COLUMNS) && (32'(cur_row) < MAX_ROWS);
  end

  // memory port control
  always_comb begin
    if (state == ST_STEP_RD) begin
      mem_raddr = {row_full[ROW_W-1:0], col_full[COL_W-1:0]};
    end else begin
      mem_raddr = {ROW_W'(cur_row), COL_W'(cur_col)};
    end
    if (state == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '{marked: 1'b0, color: 3'd0, depth: DEPTH_EMPTY};
    end else begin
      mem_we    = (state == ST_STEP_WR) && pass;
      mem_waddr = st_addr;
      mem_wdata = '{marked: 1'b1, color: cur_color, depth: st_z};
    end
  end

  // frame memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  // next state and unit strobes
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          unique case (item.mode)
            MODE_CLEAR:             state_next = ST_CLEAR;
            MODE_POINT, MODE_LINE:  state_next = ST_PRJ_Z;
            MODE_READ:              state_next = ST_READ;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_addr == ADDR_W'(CELLS - 1)) begin
          state_next = clr_item ? ST_DONE : ST_IDLE;
        end
      end
      ST_PRJ_Z:   state_next = ST_PRJ_MUL;
      ST_PRJ_MUL: state_next = ST_PRJ_SUM;
      ST_PRJ_SUM: state_next = ST_PRJ_DIV;
      ST_PRJ_DIV: begin
        div_start  = 1'b1;
        state_next = ST_PRJ_WAIT;
      end
      ST_PRJ_WAIT: begin
        if (div_stat.done) begin
          if (cur_mode == MODE_POINT && proj_idx == 2'd1) begin
            state_next = ST_SETUP;
          end else if (proj_idx == 2'd3) begin
            state_next = ST_DELTA;
          end else begin
            state_next = ST_PRJ_Z;
          end
        end
      end
      ST_DELTA:    state_next = ST_SQ_A;
      ST_SQ_A:     state_next = ST_SQ_B;
      ST_SQ_B:     state_next = ST_LEN_SQRT;
      ST_LEN_SQRT: begin
        sqrt_start = 1'b1;
        state_next = ST_LEN_WAIT;
      end
      ST_LEN_WAIT: begin
        if (sqrt_stat.done) begin
          state_next = (n_full == '0) ? ST_DONE : ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!(|u[31:15]) && !(|v[31:15])) begin
          state_next = ST_UV_A;
        end
      end
      ST_UV_A:      state_next = ST_UV_B;
      ST_UV_B:      state_next = ST_UNIT_SQRT;
      ST_UNIT_SQRT: begin
        sqrt_start = 1'b1;
        state_next = ST_UNIT_WAIT;
      end
      ST_UNIT_WAIT: begin
        if (sqrt_stat.done) begin
          state_next = ST_INC_DIV;
        end
      end
      ST_INC_DIV: begin
        div_start  = 1'b1;
        state_next = ST_INC_WAIT;
      end
      ST_INC_WAIT: begin
        if (div_stat.done) begin
          state_next = (inc_idx == 2'd2) ? ST_SETUP : ST_INC_DIV;
        end
      end
      ST_SETUP:   state_next = ST_STEP_RD;
      ST_STEP_RD: state_next = ST_STEP_WR;
      ST_STEP_WR: begin
        state_next = (STEP_W'(k + 1'b1) == n) ? ST_DONE : ST_STEP_RD;
      end
      ST_READ:      state_next = ST_READ_DATA;
      ST_READ_DATA: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      clr_item      <= 1'b0;
      out_valid     <= 1'b0;
      screen_width  <= 8'd80;
      screen_height <= 7'd40;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == ST_IDLE && item.valid) begin
        clr_item <= (item.mode == MODE_CLEAR);
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg.data;
          REG_SCREEN_HEIGHT: screen_height <= cfg.data[6:0];
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item.valid) begin
          cur_mode   <= item.mode;
          cur_sx     <= item.start_x;
          cur_sy     <= item.start_y;
          cur_sz     <= item.start_z;
          cur_ex     <= item.end_x;
          cur_ey     <= item.end_y;
          cur_ez     <= item.end_z;
          cur_color  <= item.line_color;
          cur_col    <= item.read_column;
          cur_row    <= item.read_row;
          proj_idx   <= 2'd0;
          res_marked <= 1'b0;
          res_color  <= 3'd0;
          res_depth  <= '0;
          count      <= '0;
          trunc      <= 1'b0;
        end
      end
      ST_PRJ_Z:   zz <= zz_c;
      ST_PRJ_MUL: begin
        t1 <= T1_W'(p_coord) * T1_W'(PROJ_SCALE);
        t2 <= T2_W'(signed'({1'b0, p_span})) * T2_W'(zz);
      end
      ST_PRJ_SUM: num <= NUM_W'(t1) + NUM_W'(t2);
      ST_PRJ_DIV: q_neg <= num[NUM_W-1] ^ zz[ZZ_W-1];
      ST_PRJ_WAIT: begin
        if (div_stat.done) begin
          pc[proj_idx] <= q_neg ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
          proj_idx     <= proj_idx + 1'b1;
        end
      end
      ST_DELTA: begin
        dx_neg <= dx[32];
        dy_neg <= dy[32];
        dz_neg <= dz[32];
        ax     <= dx[32] ? 32'(-dx) : dx[31:0];
        ay     <= dy[32] ? 32'(-dy) : dy[31:0];
        az     <= dz[32] ? 32'(-dz) : dz[31:0];
      end
      ST_SQ_A, ST_UV_A: sq_a <= sq_p;
      ST_SQ_B, ST_UV_B: sq_b <= sq_p;
      ST_LEN_WAIT: begin
        if (sqrt_stat.done) begin
          if (n_full > 33'(MAX_STEPS)) begin
            n     <= STEP_W'(MAX_STEPS);
            trunc <= 1'b1;
          end else begin
            n <= STEP_W'(n_full);
          end
          u  <= ax;
          v  <= ay;
          sh <= '0;
        end
      end
      ST_SHIFT: begin
        if ((|u[31:15]) || (|v[31:15])) begin
          u  <= u >> 1;
          v  <= v >> 1;
          sh <= sh + 1'b1;
        end
      end
      ST_UNIT_WAIT: begin
        if (sqrt_stat.done) begin
          lq      <= sqrt_root;
          inc_idx <= 2'd0;
        end
      end
      ST_INC_WAIT: begin
        if (div_stat.done) begin
          inc_idx <= inc_idx + 1'b1;
          unique case (inc_idx)
            2'd0:    incx <= dx_neg ? -$signed(div_q) : $signed(div_q);
            2'd1:    incy <= dy_neg ? -$signed(div_q) : $signed(div_q);
            default: incz <= dz_neg ? -$signed(inc_mag) : $signed(inc_mag);
          endcase
        end
      end
      ST_SETUP: begin
        px <= {{32{pc[0][31]}}, pc[0]} << 30;
        py <= {{32{pc[1][31]}}, pc[1]} << 30;
        pz <= {{32{cur_sz[31]}}, cur_sz} << 14;
        k  <= '0;
        if (cur_mode == MODE_POINT) begin
          incx <= '0;
          incy <= '0;
          incz <= '0;
          n    <= STEP_W'(1);
        end
      end
      ST_STEP_RD: begin
        st_on   <= on_screen;
        st_z    <= zq;
        st_addr <= {row_full[ROW_W-1:0], col_full[COL_W-1:0]};
      end
      ST_STEP_WR: begin
        if (pass && count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
        px <= px + incx;
        py <= py + incy;
        pz <= pz + incz;
        k  <= k + 1'b1;
      end
      ST_READ_DATA: begin
        if (rd_in_range) begin
          res_marked <= mem_rdata.marked;
          res_color  <= mem_rdata.color;
          res_depth  <= mem_rdata.depth;
        end else begin
          res_depth  <= DEPTH_EMPTY;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_marked <= res_marked;
          out_color  <= res_color;
          out_depth  <= res_depth;
          out_count  <= count;
          out_trunc  <= trunc;
        end
      end
      default: begin
      end
    endcase
  end

  // ports
  assign item.ready           = (state == ST_IDLE);
  assign cfg.ready            = 1'b1;
  assign result.valid         = out_valid;
  assign result.cell_marked   = out_marked;
  assign result.cell_color    = out_color;
  assign result.cell_depth    = out_depth;
  assign result.cells_written = out_count;
  assign result.truncated     = out_trunc;

  // shared divider and square root
  dtlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .stat     (div_stat),
    .quotient (div_q)
  );

  dtlr_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .stat     (sqrt_stat),
    .root     (sqrt_root),
    .rem_nz   (sqrt_rem_nz)
  );

  // checks
  `DTLR_CHECK_NEXT(a_accept_leaves_idle, clk, rst, item.valid && item.ready, state != ST_IDLE)
  `DTLR_CHECK_NOW(a_step_in_range, clk, rst, state == ST_STEP_RD, k < n)
  `DTLR_CHECK_NOW(a_div_start_idle, clk, rst, div_start, !div_stat.busy)
  `DTLR_CHECK_NOW(a_sqrt_start_idle, clk, rst, sqrt_start, !sqrt_stat.busy)

endmodule
